@@ hdl/msrq_pkg.sv @@
// Shared types and constants for the multi-slot ring queue.
`default_nettype none
package msrq_pkg;

   // Operation codes carried in the low bits of the request beat
   typedef enum logic [2:0] {
      OP_ENQUEUE   = 3'd0,
      OP_DEQUEUE   = 3'd1,
      OP_PEEK      = 3'd2,
      OP_ADVANCE   = 3'd3,
      OP_CLEAR     = 3'd4,
      OP_CLEAR_ALL = 3'd5
   } op_type;

   localparam int OP_W        = 3;
   localparam int SLOT_FIELD_W = 3;
   localparam int DATA_W      = 64;

   // Request beat: op, slot, write_data from bit 0 up, padded to bytes
   localparam int REQ_OP_LSB   = 0;
   localparam int REQ_SLOT_LSB = REQ_OP_LSB + OP_W;
   localparam int REQ_DATA_LSB = REQ_SLOT_LSB + SLOT_FIELD_W;
   localparam int REQ_USED_W   = REQ_DATA_LSB + DATA_W;
   localparam int REQ_TDATA_W  = ((REQ_USED_W + 7) / 8) * 8;

   // Response beat: ok, read_data from bit 0 up, padded to bytes
   localparam int RSP_USED_W  = 1 + DATA_W;
   localparam int RSP_TDATA_W = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_USED_W;

endpackage
`default_nettype wire

@@ hdl/multi_slot_ring_queue.sv @@
// Top level of the multi-slot ring queue: pointer control, RAM and stream ports.
`default_nettype none
// One circular report queue per device slot. Every request beat carries an
// operation (enqueue, dequeue, peek, advance head, clear slot, clear all), a
// slot number and a report word, and yields exactly one response beat with an
// ok flag and the read report (zero unless a dequeue or peek succeeded). Each
// queue holds QUEUE_DEPTH-1 reports; one entry stays empty to tell full from
// empty. Head and tail indexes live in flip-flops, so clear-all empties every
// queue at once, and all reports share one RAM of SLOT_COUNT x QUEUE_DEPTH words
// (rounded up to powers of two) with a registered read. A request is taken every
// cycle while the response side keeps up: a response passes through the pending
// stage (RAM read), then the output register, and one further request may be
// taken while a response is stalled on rsp_tready. Report words are kept to
// their low REPORT_WIDTH bits. No initialization pass after reset.
module multi_slot_ring_queue #(
   parameter int SLOT_COUNT   = 4,
   parameter int QUEUE_DEPTH  = 16,
   parameter int REPORT_WIDTH = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request: [2:0] op, [5:3] slot, [69:6] write_data, [71:70] zero
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [msrq_pkg::REQ_TDATA_W-1:0] req_tdata,
   // response: [0] ok, [64:1] read_data, [71:65] zero
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [msrq_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int IDX_W  = $clog2(QUEUE_DEPTH);
   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int ADDR_W = SLOT_W + IDX_W;
   localparam int RAM_DEPTH = 2 ** ADDR_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

   // ---------------------------------------------------------------
   // Request fields
   // ---------------------------------------------------------------
   msrq_pkg::op_type                req_op;
   logic [msrq_pkg::SLOT_FIELD_W-1:0] req_slot;
   logic [REPORT_WIDTH-1:0]         req_report;
   logic [SLOT_W-1:0]               slot_idx;
   logic                            slot_ok;

   assign req_op     = msrq_pkg::op_type'(req_tdata[msrq_pkg::REQ_OP_LSB +: msrq_pkg::OP_W]);
   assign req_slot   = req_tdata[msrq_pkg::REQ_SLOT_LSB +: msrq_pkg::SLOT_FIELD_W];
   // drop report bits above REPORT_WIDTH
   assign req_report = req_tdata[msrq_pkg::REQ_DATA_LSB +: REPORT_WIDTH];
   assign slot_idx   = SLOT_W'(req_slot);
   assign slot_ok    = (int'(req_slot) < SLOT_COUNT);

   // ---------------------------------------------------------------
   // Pointer state, one head and one tail per slot
   // ---------------------------------------------------------------
   logic [IDX_W-1:0] head_ff [SLOT_COUNT];
   logic [IDX_W-1:0] tail_ff [SLOT_COUNT];
   logic [IDX_W-1:0] head_in [SLOT_COUNT];
   logic [IDX_W-1:0] tail_in [SLOT_COUNT];

   logic [IDX_W-1:0] cur_head;
   logic [IDX_W-1:0] cur_tail;
   logic [IDX_W-1:0] next_head;
   logic [IDX_W-1:0] next_tail;
   logic             q_empty;
   logic             q_full;

   assign cur_head  = slot_ok ? head_ff[slot_idx] : '0;
   assign cur_tail  = slot_ok ? tail_ff[slot_idx] : '0;
   assign next_head = (cur_head == LAST_IDX) ? '0 : cur_head + IDX_W'(1);
   assign next_tail = (cur_tail == LAST_IDX) ? '0 : cur_tail + IDX_W'(1);
   assign q_empty   = (cur_head == cur_tail);
   assign q_full    = (next_tail == cur_head);

   // ---------------------------------------------------------------
   // Pipeline: pending stage waits for RAM data, output register drives rsp
   // ---------------------------------------------------------------
   logic pend_valid_ff, pend_valid_in;
   logic pend_ok_ff,    pend_ok_in;
   logic pend_read_ff,  pend_read_in;
   logic rsp_valid_ff,  rsp_valid_in;
   logic rsp_ok_ff,     rsp_ok_in;
   logic [msrq_pkg::DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic rsp_load;
   logic req_fire;

   // move the pending beat out when the output register is free or draining
   assign rsp_load   = pend_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !pend_valid_ff || rsp_load;
   assign req_fire   = req_tvalid && req_tready;

   // ---------------------------------------------------------------
   // RAM access
   // ---------------------------------------------------------------
   logic                    ram_wr_en;
   logic                    ram_rd_en;
   logic [ADDR_W-1:0]       ram_wr_addr;
   logic [ADDR_W-1:0]       ram_rd_addr;
   logic [REPORT_WIDTH-1:0] ram_rd_data;

   assign ram_wr_addr = {slot_idx, cur_tail};
   assign ram_rd_addr = {slot_idx, cur_head};

   msrq_ram #(
      .WIDTH (REPORT_WIDTH),
      .DEPTH (RAM_DEPTH)
   ) u_report_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_report),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------
   // Operation decode: pointer updates, RAM strobes, ok flag
   // ---------------------------------------------------------------
   logic op_ok;
   logic op_read;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      ram_wr_en = 1'b0;
      ram_rd_en = 1'b0;
      op_ok     = 1'b0;
      op_read   = 1'b0;
      if (req_fire) begin
         case (req_op)
            msrq_pkg::OP_ENQUEUE: begin
               if (slot_ok && !q_full) begin
                  ram_wr_en         = 1'b1;
                  tail_in[slot_idx] = next_tail;
                  op_ok             = 1'b1;
               end
            end
            msrq_pkg::OP_DEQUEUE: begin
               if (slot_ok && !q_empty) begin
                  ram_rd_en         = 1'b1;
                  head_in[slot_idx] = next_head;
                  op_ok             = 1'b1;
                  op_read           = 1'b1;
               end
            end
            msrq_pkg::OP_PEEK: begin
               if (slot_ok && !q_empty) begin
                  ram_rd_en = 1'b1;
                  op_ok     = 1'b1;
                  op_read   = 1'b1;
               end
            end
            msrq_pkg::OP_ADVANCE: begin
               if (slot_ok && !q_empty) begin
                  head_in[slot_idx] = next_head;
                  op_ok             = 1'b1;
               end
            end
            msrq_pkg::OP_CLEAR: begin
               if (slot_ok) begin
                  head_in[slot_idx] = '0;
                  tail_in[slot_idx] = '0;
                  op_ok             = 1'b1;
               end
            end
            msrq_pkg::OP_CLEAR_ALL: begin
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  head_in[i] = '0;
                  tail_in[i] = '0;
               end
               op_ok = 1'b1;
            end
            default: begin
               // undefined codes: refuse, change nothing
               op_ok = 1'b0;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Next values of the pending stage and output register
   // ---------------------------------------------------------------
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_ok_in    = pend_ok_ff;
      pend_read_in  = pend_read_ff;
      if (rsp_load) begin
         pend_valid_in = 1'b0;
      end
      if (req_fire) begin
         pend_valid_in = 1'b1;
         pend_ok_in    = op_ok;
         pend_read_in  = op_read;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = pend_ok_ff;
         // RAM data is valid only for a successful dequeue or peek
         rsp_data_in  = pend_read_ff ? msrq_pkg::DATA_W'(ram_rd_data) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      // payload, no reset needed
      pend_ok_ff   <= pend_ok_in;
      pend_read_ff <= pend_read_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{msrq_pkg::RSP_PAD_W{1'b0}}, rsp_data_ff, rsp_ok_ff};

endmodule
`default_nettype wire

@@ hdl/msrq_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none
module msrq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ verif/tb_multi_slot_ring_queue.sv @@
// Self-checking stream testbench for the multi-slot ring queue.
`timescale 1ns / 1ps
module tb_multi_slot_ring_queue;

   localparam int SLOT_COUNT   = 4;
   localparam int QUEUE_DEPTH  = 16;
   localparam int REPORT_WIDTH = 64;
   localparam int IDX_W        = $clog2(QUEUE_DEPTH);

   // Codes 6 and 7 are not part of the operation set and must be refused
   localparam logic [msrq_pkg::OP_W-1:0] OP_UNDEF_LO = 3'd6;
   localparam logic [msrq_pkg::OP_W-1:0] OP_UNDEF_HI = 3'd7;

   localparam logic [msrq_pkg::DATA_W-1:0] REPORT_MASK =
      {msrq_pkg::DATA_W{1'b1}} >> (msrq_pkg::DATA_W - REPORT_WIDTH);

   localparam int RANDOM_ITEMS  = 950;
   localparam int HOLDOFF_AT    = 400;  // response count that arms the long hold-off
   localparam int HOLDOFF_LEN   = 300;  // cycles the receiver refuses beats
   localparam int IDLE_LIMIT    = 3000; // cycles without any beat before giving up
   localparam int TAIL_CYCLES   = 8;    // settle time once nothing is outstanding

   typedef struct {
      logic [msrq_pkg::OP_W-1:0]         op;
      logic [msrq_pkg::SLOT_FIELD_W-1:0] slot;
      logic [msrq_pkg::DATA_W-1:0]       wdata;
      int                                gap_after;  // idle cycles after this beat is taken
      bit                                wait_idle;  // hold until every response is back
   } req_item_type;

   typedef struct {
      logic                        ok;
      logic [msrq_pkg::DATA_W-1:0] rdata;
   } rsp_beat_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [msrq_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [msrq_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   multi_slot_ring_queue #(
      .SLOT_COUNT  (SLOT_COUNT),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .REPORT_WIDTH(REPORT_WIDTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Shadow copy of the queues: per-slot head/tail and the report words
   // ---------------------------------------------------------------------
   logic [IDX_W-1:0]            head_idx [SLOT_COUNT];
   logic [IDX_W-1:0]            tail_idx [SLOT_COUNT];
   logic [msrq_pkg::DATA_W-1:0] report_mem [SLOT_COUNT][QUEUE_DEPTH];

   req_item_type pending_req_q[$];
   rsp_beat_type expected_rsp_q[$];

   int errors      = 0;
   int req_count   = 0;
   int rsp_count   = 0;
   int n_ok        = 0;
   int n_full      = 0;  // enqueue refused on a full queue
   int n_empty     = 0;  // dequeue, peek or advance refused on an empty queue
   int n_bad       = 0;  // out-of-range slot or undefined code
   int n_wraps     = 0;  // tail wrapped past the last entry
   bit holdoff_done = 1'b0;

   function automatic logic [IDX_W-1:0] bump_idx(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + IDX_W'(1);
   endfunction

   // Apply one request to the shadow queues and return the response it owes
   function automatic rsp_beat_type apply_queue_op(input req_item_type it);
      rsp_beat_type     r;
      logic [IDX_W-1:0] h;
      logic [IDX_W-1:0] t;
      bit               empty;
      r.ok    = 1'b0;
      r.rdata = '0;
      if (it.op == msrq_pkg::OP_CLEAR_ALL) begin
         for (int s = 0; s < SLOT_COUNT; s++) begin
            head_idx[s] = '0;
            tail_idx[s] = '0;
         end
         r.ok = 1'b1;
      end else if (it.op <= msrq_pkg::OP_CLEAR && it.slot < SLOT_COUNT) begin
         h     = head_idx[it.slot];
         t     = tail_idx[it.slot];
         empty = (h == t);
         case (it.op)
            msrq_pkg::OP_ENQUEUE: begin
               if (bump_idx(t) != h) begin
                  report_mem[it.slot][t] = it.wdata & REPORT_MASK;
                  tail_idx[it.slot]      = bump_idx(t);
                  if (t == IDX_W'(QUEUE_DEPTH - 1)) n_wraps++;
                  r.ok = 1'b1;
               end else begin
                  n_full++;
               end
            end
            msrq_pkg::OP_DEQUEUE, msrq_pkg::OP_PEEK: begin
               if (!empty) begin
                  r.rdata = report_mem[it.slot][h] & REPORT_MASK;
                  if (it.op == msrq_pkg::OP_DEQUEUE) head_idx[it.slot] = bump_idx(h);
                  r.ok = 1'b1;
               end else begin
                  n_empty++;
               end
            end
            msrq_pkg::OP_ADVANCE: begin
               if (!empty) begin
                  head_idx[it.slot] = bump_idx(h);
                  r.ok = 1'b1;
               end else begin
                  n_empty++;
               end
            end
            default: begin
               head_idx[it.slot] = '0;
               tail_idx[it.slot] = '0;
               r.ok = 1'b1;
            end
         endcase
      end else begin
         n_bad++;
      end
      if (r.ok) n_ok++;
      return r;
   endfunction

   // Idle length: mostly none or short, now and then a long one
   function automatic int draw_gap();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(3, 1);
      if (pick < 97) return $urandom_range(12, 4);
      return $urandom_range(50, 20);
   endfunction

   task automatic add_req(input logic [msrq_pkg::OP_W-1:0] op,
                          input logic [msrq_pkg::SLOT_FIELD_W-1:0] slot,
                          input logic [msrq_pkg::DATA_W-1:0] wdata, input int gap,
                          input bit wait_idle);
      req_item_type it;
      it.op        = op;
      it.slot      = slot;
      it.wdata     = wdata;
      it.gap_after = gap;
      it.wait_idle = wait_idle;
      pending_req_q.push_back(it);
   endtask

   // ---------------------------------------------------------------------
   // Request driver: offer the next pending item, predict on acceptance
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      req_item_type cur_item;
      int           gap_left;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         gap_left   = 0;
      end else begin
         // Beat taken at this edge: record what it must produce
         if (req_tvalid && req_tready) begin
            expected_rsp_q.push_back(apply_queue_op(cur_item));
            req_count++;
            gap_left = cur_item.gap_after;
         end
         // Advance only once the current beat is gone
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_req_q.size() != 0 &&
                         !(pending_req_q[0].wait_idle && expected_rsp_q.size() != 0)) begin
               cur_item = pending_req_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {{(msrq_pkg::REQ_TDATA_W - msrq_pkg::REQ_USED_W){1'b0}},
                              cur_item.wdata, cur_item.slot, cur_item.op};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor: compare each beat with the oldest expectation and
   // pace rsp_tready, including one long hold-off while requests keep coming
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      rsp_beat_type want;
      int           stall_left;
      int           hold_left;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (expected_rsp_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected response beat, nothing expected, got %h",
                        $time, rsp_tdata);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_tdata[0] !== want.ok) begin
                  errors++;
                  $display("%0t: ok mismatch, expected %0b, got %0b",
                           $time, want.ok, rsp_tdata[0]);
               end
               if (rsp_tdata[msrq_pkg::DATA_W:1] !== want.rdata) begin
                  errors++;
                  $display("%0t: read_data mismatch, expected %h, got %h",
                           $time, want.rdata, rsp_tdata[msrq_pkg::DATA_W:1]);
               end
               if (rsp_tdata[msrq_pkg::RSP_TDATA_W-1:msrq_pkg::RSP_USED_W] !== '0) begin
                  errors++;
                  $display("%0t: padding mismatch, expected 0, got %h",
                           $time, rsp_tdata[msrq_pkg::RSP_TDATA_W-1:msrq_pkg::RSP_USED_W]);
               end
            end
            // Draw a stall after some beats, except in the quiet windows
            if (rsp_count[7:6] != 2'b00 && $urandom_range(99) < 30)
               stall_left = draw_gap();
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!holdoff_done && rsp_count >= HOLDOFF_AT && req_tvalid) begin
            // Sender is offering: refuse long enough for the block to back up
            holdoff_done = 1'b1;
            hold_left    = HOLDOFF_LEN;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: abort when no beat moves on either side for too long
   always @(posedge clock) begin : idle_watchdog
      int idle_cycles;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d responses outstanding",
                     $time, IDLE_LIMIT, expected_rsp_q.size());
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int                                made;
      int                                mode;
      int                                block_len;
      int                                pick;
      bit                                no_gaps;
      bit                                first_block;
      logic [msrq_pkg::OP_W-1:0]         op;
      logic [msrq_pkg::SLOT_FIELD_W-1:0] slot;
      logic [msrq_pkg::SLOT_FIELD_W-1:0] focus;

      for (int s = 0; s < SLOT_COUNT; s++) begin
         head_idx[s] = '0;
         tail_idx[s] = '0;
      end

      // Directed: empty refusals, data extremes, every operation,
      // out-of-range slots and undefined codes
      add_req(msrq_pkg::OP_DEQUEUE,   3'd0, '0, 0, 1'b0);
      add_req(msrq_pkg::OP_PEEK,      3'd1, '0, 0, 1'b0);
      add_req(msrq_pkg::OP_ADVANCE,   3'd2, '1, 0, 1'b0);
      add_req(msrq_pkg::OP_ENQUEUE,   3'd0, '1, 0, 1'b0);
      add_req(msrq_pkg::OP_ENQUEUE,   3'd0, '0, 0, 1'b0);
      add_req(msrq_pkg::OP_ENQUEUE,   3'd0, 64'h8000_0000_0000_0001, 0, 1'b0);
      add_req(msrq_pkg::OP_PEEK,      3'd0, '0, 0, 1'b0);
      add_req(msrq_pkg::OP_DEQUEUE,   3'd0, '0, 0, 1'b0);
      add_req(msrq_pkg::OP_ADVANCE,   3'd0, '0, 0, 1'b0);
      add_req(msrq_pkg::OP_DEQUEUE,   3'd0, '0, 0, 1'b0);
      add_req(msrq_pkg::OP_DEQUEUE,   3'd0, '0, 0, 1'b0);
      add_req(msrq_pkg::OP_ENQUEUE,   3'd4, 64'hAAAA_AAAA_AAAA_AAAA, 0, 1'b0);
      add_req(msrq_pkg::OP_ENQUEUE,   3'd7, 64'h5555_5555_5555_5555, 0, 1'b0);
      add_req(msrq_pkg::OP_DEQUEUE,   3'd5, '0, 0, 1'b0);
      add_req(msrq_pkg::OP_CLEAR,     3'd6, '0, 0, 1'b0);
      add_req(OP_UNDEF_LO,            3'd1, '1, 0, 1'b0);
      add_req(OP_UNDEF_HI,            3'd7, '1, 0, 1'b0);
      add_req(msrq_pkg::OP_ENQUEUE,   3'd3, 64'h0123_4567_89AB_CDEF, 0, 1'b0);
      add_req(msrq_pkg::OP_CLEAR,     3'd3, '0, 0, 1'b0);
      add_req(msrq_pkg::OP_PEEK,      3'd3, '0, 0, 1'b0);
      add_req(msrq_pkg::OP_ENQUEUE,   3'd1, 64'hFEDC_BA98_7654_3210, 0, 1'b0);
      add_req(msrq_pkg::OP_ENQUEUE,   3'd2, 64'h0F0F_0F0F_F0F0_F0F0, 0, 1'b0);
      add_req(msrq_pkg::OP_CLEAR_ALL, 3'd7, '0, 0, 1'b0);
      add_req(msrq_pkg::OP_PEEK,      3'd1, '0, 0, 1'b0);
      add_req(msrq_pkg::OP_DEQUEUE,   3'd2, '0, 0, 1'b0);

      // Random: blocks that fill one slot, drain it, mix, or throw noise
      made        = 0;
      first_block = 1'b1;
      while (made < RANDOM_ITEMS) begin
         mode      = $urandom_range(99);
         block_len = $urandom_range(60, 10);
         no_gaps   = ($urandom_range(3) == 0);
         focus     = msrq_pkg::SLOT_FIELD_W'($urandom_range(SLOT_COUNT - 1));
         for (int i = 0; i < block_len && made < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(99);
            slot = ($urandom_range(3) == 0) ?
                   msrq_pkg::SLOT_FIELD_W'($urandom_range(SLOT_COUNT - 1)) : focus;
            if (mode < 30) begin
               // fill: mostly enqueues, aiming to reach full and wrap the tail
               op = (pick < 75) ? msrq_pkg::OP_ENQUEUE :
                    (pick < 85) ? msrq_pkg::OP_PEEK : msrq_pkg::OP_DEQUEUE;
            end else if (mode < 55) begin
               // drain: run the queue empty and beyond
               op = (pick < 45) ? msrq_pkg::OP_DEQUEUE : (pick < 70) ? msrq_pkg::OP_ADVANCE :
                    (pick < 85) ? msrq_pkg::OP_PEEK : msrq_pkg::OP_ENQUEUE;
            end else if (mode < 90) begin
               if (pick < 3)       op = msrq_pkg::OP_CLEAR_ALL;
               else if (pick < 6)  op = msrq_pkg::OP_CLEAR;
               else if (pick < 40) op = msrq_pkg::OP_ENQUEUE;
               else if (pick < 65) op = msrq_pkg::OP_DEQUEUE;
               else if (pick < 82) op = msrq_pkg::OP_PEEK;
               else                op = msrq_pkg::OP_ADVANCE;
               slot = msrq_pkg::SLOT_FIELD_W'($urandom_range(SLOT_COUNT - 1));
            end else begin
               // noise: any code, any slot
               op   = msrq_pkg::OP_W'($urandom_range(7));
               slot = msrq_pkg::SLOT_FIELD_W'($urandom_range(7));
            end
            add_req(op, slot, {$urandom, $urandom}, no_gaps ? 0 : draw_gap(),
                    (i == 0) && (first_block || $urandom_range(6) == 0));
            first_block = 1'b0;
            made++;
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Hold until every request has gone out and every response is back
      while (pending_req_q.size() != 0 || req_tvalid || expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d requests: %0d ok, %0d full, %0d empty, %0d bad slot or code",
               req_count, n_ok, n_full, n_empty, n_bad);
      $display("Tail wrapped %0d times; one long response hold-off %0s",
               n_wraps, holdoff_done ? "applied" : "not reached");
      if (errors == 0 && expected_rsp_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d responses missing", errors, expected_rsp_q.size());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
